FILE: rtl/cbwc_pkg.sv
// Package for the coprocessor bank window control unit.
// Holds word types, action and register codes and control constants.
// No dependencies; imported by every module of the block.
package cbwc_pkg;

    // action codes of the input word
    localparam logic [1:0] ACT_HOST_REG    = 2'd0;
    localparam logic [1:0] ACT_HOST_WINDOW = 2'd1;
    localparam logic [1:0] ACT_COPRO       = 2'd2;

    // configuration register indexes
    localparam logic CFG_VERSION_ONE = 1'b0;
    localparam logic CFG_RANDOM_SEED = 1'b1;

    localparam int unsigned SEED_W = 31;

    // control byte constants
    localparam logic [7:0] HOST_FORCE_BITS  = 8'h44;
    localparam logic [7:0] COPRO_FORCE_BITS = 8'h1F;
    localparam logic [7:0] COPRO_RUN_BITS   = 8'h3F;
    localparam logic [7:0] HOST_RESET_VAL   = 8'hCC;
    localparam logic [7:0] COPRO_RESET_VAL  = 8'h3F;

    // coprocessor register mirror 0x200-0x20F, compared on address[15:4]
    localparam logic [11:0] COPRO_REG_PAGE = 12'h020;

    // host window halves, compared on address[15:13]
    localparam logic [2:0] HOST_WIN_LOW  = 3'b100;
    localparam logic [2:0] HOST_WIN_HIGH = 3'b101;

    // coprocessor active window, compared on address[15:14]
    localparam logic [1:0] COPRO_WIN_LOW  = 2'b01;
    localparam logic [1:0] COPRO_WIN_HIGH = 2'b11;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic        write;
        logic [7:0]  write_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [16:0] phys_address;
        logic        mapped;
        logic        is_register;
        logic        corrupt;
        logic [7:0]  corrupt_mask;
        logic        coproc_run;
        logic        coproc_restart;
        logic        rd5_active;
    } out_word_t;

    // architectural state passed between the state holder and the mapper
    typedef struct packed {
        logic [7:0]  host_control;
        logic [7:0]  copro_control;
        logic        corrupt_pending;
        logic [31:0] random_state;
    } ctl_state_t;

endpackage

FILE: rtl/cbwc_map.sv
// Address mapper and control byte update logic of the bank window unit.
// Purely combinational: one input word plus current state gives the result
// word and the next state. Depends on cbwc_pkg.
module cbwc_map (
    input  cbwc_pkg::in_word_t   item,
    input  cbwc_pkg::ctl_state_t cur,
    input  logic                 version_one,
    output cbwc_pkg::out_word_t  result,
    output cbwc_pkg::ctl_state_t nxt
);
    import cbwc_pkg::*;

    logic [7:0]  host_v;
    logic [7:0]  host_delta;
    logic [7:0]  copro_v;
    logic [7:0]  copro_delta;
    logic [15:0] draw;
    logic [31:0] rng_next;
    logic        host_on;
    logic        is_reg;
    logic        in_active;
    logic [1:0]  active_sel;

    // shared decode of both control bytes and the random draw
    always_comb begin
        host_v      = item.write_data | HOST_FORCE_BITS;
        host_delta  = cur.host_control ^ host_v;
        copro_v     = item.write_data | COPRO_FORCE_BITS;
        copro_delta = cur.copro_control ^ copro_v;
        draw        = cur.random_state[15:0];
        rng_next    = ({16'd0, draw} << 12) ^ ({16'd0, draw} << 15)
                    ^ (cur.random_state >> 16);
        case (item.address[15:13])
            HOST_WIN_LOW:  host_on = cur.host_control[4];
            HOST_WIN_HIGH: host_on = cur.host_control[5];
            default:       host_on = 1'b0;
        endcase
        is_reg     = (item.address[15:4] == COPRO_REG_PAGE);
        active_sel = cur.copro_control[6] ? COPRO_WIN_LOW : COPRO_WIN_HIGH;
        in_active  = (item.address[15:14] == active_sel);
    end

    // per-action result and state update
    always_comb begin
        nxt    = cur;
        result = '0;
        case (item.action)
            ACT_HOST_REG: begin
                if (!item.write) begin
                    result.read_data = cur.host_control;
                end else begin
                    if (host_delta[7]) begin
                        nxt.copro_control[7] = ~host_v[7];
                    end
                    nxt.host_control = host_v;
                    if (host_delta[0]) begin
                        nxt.copro_control   = {nxt.copro_control[7], 7'd0} | COPRO_RUN_BITS;
                        nxt.corrupt_pending = 1'b0;
                    end
                    result.coproc_restart = host_delta[0] & host_v[0];
                    if (version_one && host_delta[1] && host_v[0] && !host_delta[0]) begin
                        nxt.corrupt_pending = 1'b1;
                    end
                end
            end
            ACT_HOST_WINDOW: begin
                if (host_on) begin
                    result.phys_address = {1'b1, cur.host_control[1], cur.host_control[3],
                                           item.address[13:0]};
                    result.mapped       = 1'b1;
                end
            end
            ACT_COPRO: begin
                nxt.corrupt_pending = 1'b0;
                if (is_reg) begin
                    result.is_register = 1'b1;
                    if (!item.write) begin
                        result.read_data = cur.copro_control;
                    end else begin
                        nxt.copro_control = copro_v;
                        if (copro_delta[7]) begin
                            nxt.host_control[7] = ~copro_v[7];
                        end
                    end
                end else if (in_active) begin
                    result.phys_address = {1'b1, ~cur.host_control[1], cur.copro_control[5],
                                           item.address[13:0]};
                    result.mapped       = 1'b1;
                    if (cur.corrupt_pending) begin
                        nxt.random_state = rng_next;
                        if (draw[4:0] == 5'd0) begin
                            result.corrupt      = 1'b1;
                            result.corrupt_mask = draw[15:8];
                        end
                    end
                end else begin
                    result.phys_address = {1'b0, item.address};
                    result.mapped       = 1'b1;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        result.coproc_run = nxt.host_control[0];
        result.rd5_active = nxt.host_control[5];
    end

endmodule

FILE: rtl/cbwc_state.sv
// State registers of the bank window unit: control bytes, pending flag,
// random generator and the two configuration registers.
// Depends on cbwc_pkg.
module cbwc_state (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [cbwc_pkg::SEED_W-1:0]    cfg_wdata,
    input  logic                           update,
    input  logic                           copro_access,
    input  cbwc_pkg::ctl_state_t           nxt,
    output cbwc_pkg::ctl_state_t           cur,
    output logic                           version_one
);
    import cbwc_pkg::*;

    logic [7:0]  host_control_reg;
    logic [7:0]  copro_control_reg;
    logic        corrupt_pending_reg;
    logic [31:0] random_state_reg;
    logic        version_one_reg;
    logic [31:0] seed_load;

    // zero seed loads as one
    assign seed_load = (cfg_wdata == '0) ? 32'd1 : {1'b0, cfg_wdata};

    // control state and generator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_control_reg    <= HOST_RESET_VAL;
            copro_control_reg   <= COPRO_RESET_VAL;
            corrupt_pending_reg <= 1'b0;
            random_state_reg    <= 32'd1;
            version_one_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_VERSION_ONE: version_one_reg  <= cfg_wdata[0];
                CFG_RANDOM_SEED: random_state_reg <= seed_load;
                default:         version_one_reg  <= version_one_reg;
            endcase
        end else if (update) begin
            host_control_reg    <= nxt.host_control;
            copro_control_reg   <= nxt.copro_control;
            corrupt_pending_reg <= nxt.corrupt_pending;
            random_state_reg    <= nxt.random_state;
        end
    end

    assign cur.host_control    = host_control_reg;
    assign cur.copro_control   = copro_control_reg;
    assign cur.corrupt_pending = corrupt_pending_reg;
    assign cur.random_state    = random_state_reg;
    assign version_one         = version_one_reg;

    // any coprocessor access consumes the pending corruption
    a_pending_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (update && copro_access && !cfg_wr_en) |=> !corrupt_pending_reg)
        else $error("corrupt pending survived a coprocessor access");

    // host control forced bits always read as one
    a_host_forced: assert property (@(posedge aclk) disable iff (!aresetn)
        host_control_reg[2] && host_control_reg[6])
        else $error("host control forced bits cleared");

    // coprocessor low five bits always read as one
    a_copro_forced: assert property (@(posedge aclk) disable iff (!aresetn)
        copro_control_reg[4:0] == 5'h1F)
        else $error("coprocessor control forced bits cleared");

endmodule

FILE: rtl/coprocessor_bank_window_control_unit.sv
// Top level of the coprocessor bank window control unit.
// Input word register, mapper, state registers and result word register.
// Depends on cbwc_pkg, cbwc_map and cbwc_state.
//
//   channel   direction  handshake                 payload
//   s_        in         s_valid / s_ready         s_data  (in_word_t)
//   m_        out        m_valid / m_ready         m_data  (out_word_t)
//   cfg_      in         cfg_wr_en, no wait        cfg_index, cfg_wdata
//
// An accepted word passes through the input register, then through the
// mapper into the result register.
// One word per cycle is sustained while m_ready holds; state is updated as a
// word moves into the result register, so the next word sees it.
// A stalled result holds the result register and then the input register;
// s_ready drops only when both hold a word.
// aresetn is synchronous: both registers empty, control bytes at reset values.
module coprocessor_bank_window_control_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cbwc_pkg::in_word_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cbwc_pkg::out_word_t         m_data,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [cbwc_pkg::SEED_W-1:0] cfg_wdata
);
    import cbwc_pkg::*;

    in_word_t   in_word_reg;
    logic       in_valid_reg;
    out_word_t  out_word_reg;
    logic       out_valid_reg;
    out_word_t  result;
    ctl_state_t cur;
    ctl_state_t nxt;
    logic       version_one;
    logic       advance;

    // word moves from input register to result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cbwc_map u_map (
        .item        (in_word_reg),
        .cur         (cur),
        .version_one (version_one),
        .result      (result),
        .nxt         (nxt)
    );

    cbwc_state u_state (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .update       (advance),
        .copro_access (in_word_reg.action == ACT_COPRO),
        .nxt          (nxt),
        .cur          (cur),
        .version_one  (version_one)
    );

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // a restart pulse only comes with the coprocessor running
    a_restart_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.coproc_restart) |-> m_data.coproc_run)
        else $error("restart without coprocessor run");

    // corruption only on a mapped window access
    a_corrupt_mapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.corrupt) |-> (m_data.mapped && !m_data.is_register))
        else $error("corrupt flag on an unmapped access");

    // register hits never reach RAM
    a_reg_unmapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_register) |-> (!m_data.mapped && m_data.phys_address == '0))
        else $error("register access mapped to RAM");

endmodule

FILE: sim/tb_coprocessor_bank_window_control_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for coprocessor_bank_window_control_unit: directed and random
// host and coprocessor accesses, each result word predicted by an in-bench shadow model.
// Depends on cbwc_pkg and the unit's RTL only.
module tb_coprocessor_bank_window_control_unit;
    import cbwc_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [SEED_W-1:0] SEED_MAX = '1;
    // action code the unit leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_word_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_word_t         m_data;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = CFG_VERSION_ONE;
    logic [SEED_W-1:0] cfg_wdata = '0;

    // shadow of the unit's control state and settings
    logic [7:0]  host_ctl;
    logic [7:0]  copro_ctl;
    logic        swap_hazard;
    logic [31:0] noise_lfsr;
    logic        hazard_en;

    out_word_t access_results_due[$];
    out_word_t want;
    int        fail_count = 0;
    logic      no_idle    = 1'b0;

    coprocessor_bank_window_control_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // seed load, a zero seed falls back to one
    function automatic void load_noise_seed(input logic [SEED_W-1:0] seed);
        noise_lfsr = {1'b0, seed};
        if (seed == '0) noise_lfsr = 32'd1;
    endfunction

    // expected result word for one access, advances the shadow state
    function automatic out_word_t predict_access(input in_word_t w);
        out_word_t   r;
        logic [7:0]  v;
        logic [7:0]  delta;
        logic        was_armed;
        logic        on;
        logic [1:0]  active_win;
        logic [31:0] t;
        r  = '0;
        on = 1'b0;
        case (w.action)
            ACT_HOST_REG: begin
                if (!w.write) begin
                    r.read_data = host_ctl;
                end else begin
                    v     = w.write_data | HOST_FORCE_BITS;
                    delta = host_ctl ^ v;
                    // semaphore cross-link
                    if (delta[7]) copro_ctl[7] = ~v[7];
                    host_ctl = v;
                    // coprocessor reset edge reloads its control byte
                    if (delta[0]) begin
                        copro_ctl   = {copro_ctl[7], COPRO_RUN_BITS[6:0]};
                        swap_hazard = 1'b0;
                    end
                    r.coproc_restart = delta[0] & v[0];
                    // bank swap while running arms the hazard
                    if (hazard_en && delta[1] && v[0] && !delta[0]) swap_hazard = 1'b1;
                end
            end
            ACT_HOST_WINDOW: begin
                if (w.address[15:13] == HOST_WIN_LOW) on = host_ctl[4];
                else if (w.address[15:13] == HOST_WIN_HIGH) on = host_ctl[5];
                if (on) begin
                    r.phys_address = {1'b1, host_ctl[1], host_ctl[3], w.address[13:0]};
                    r.mapped       = 1'b1;
                end
            end
            ACT_COPRO: begin
                was_armed   = swap_hazard;
                swap_hazard = 1'b0;
                active_win  = copro_ctl[6] ? COPRO_WIN_LOW : COPRO_WIN_HIGH;
                if (w.address[15:4] == COPRO_REG_PAGE) begin
                    r.is_register = 1'b1;
                    if (!w.write) begin
                        r.read_data = copro_ctl;
                    end else begin
                        v         = w.write_data | COPRO_FORCE_BITS;
                        delta     = v ^ copro_ctl;
                        copro_ctl = v;
                        if (delta[7]) host_ctl[7] = ~v[7];
                    end
                end else if (w.address[15:14] == active_win) begin
                    r.phys_address = {1'b1, ~host_ctl[1], copro_ctl[5], w.address[13:0]};
                    r.mapped       = 1'b1;
                    if (was_armed) begin
                        // one 16-bit draw, corrupt when its low five bits are clear
                        t = {16'd0, noise_lfsr[15:0]};
                        noise_lfsr = (t << 12) ^ (t << 15) ^ (noise_lfsr >> 16);
                        if (t[4:0] == 5'd0) begin
                            r.corrupt      = 1'b1;
                            r.corrupt_mask = t[15:8];
                        end
                    end
                end else begin
                    r.phys_address = {1'b0, w.address};
                    r.mapped       = 1'b1;
                end
            end
            default: ;
        endcase
        r.coproc_run  = host_ctl[0];
        r.rd5_active  = host_ctl[5];
        return r;
    endfunction

    function automatic string show_word(input out_word_t w);
        return $sformatf("rd=%02h pa=%05h map=%b reg=%b cor=%b mask=%02h run=%b rst=%b rd5=%b",
                         w.read_data, w.phys_address, w.mapped, w.is_register, w.corrupt,
                         w.corrupt_mask, w.coproc_run, w.coproc_restart, w.rd5_active);
    endfunction

    function automatic void log_fail(input string what, input string exp_s, input string got_s);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected %s got %s", $realtime, what, exp_s, got_s);
    endfunction

    // host data that swaps the bank bit and keeps the coprocessor running
    function automatic logic [7:0] bank_flip_data(input logic [5:0] upper);
        return {upper, ~host_ctl[1], 1'b1};
    endfunction

    // coprocessor address in the active or the dormant window
    function automatic logic [15:0] window_addr(input logic active, input logic [13:0] low);
        logic [1:0] act_win;
        logic [1:0] dorm_win;
        act_win  = copro_ctl[6] ? COPRO_WIN_LOW : COPRO_WIN_HIGH;
        dorm_win = copro_ctl[6] ? COPRO_WIN_HIGH : COPRO_WIN_LOW;
        return {active ? act_win : dorm_win, low};
    endfunction

    // present one word, hold it until accepted, then queue its prediction
    task automatic issue_access(input logic [1:0] act, input logic [15:0] addr,
                                input logic wr, input logic [7:0] data);
        in_word_t w;
        w.action     = act;
        w.address    = addr;
        w.write      = wr;
        w.write_data = data;
        while (!no_idle && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        access_results_due.push_back(predict_access(w));
    endtask

    // stop sending and let every outstanding word come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (access_results_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_setting(input logic idx, input logic [SEED_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_VERSION_ONE) hazard_en = value[0];
        else load_noise_seed(value);
    endtask

    // weighted mix: mostly bank swap sequences, then plain traffic and noise
    task automatic run_traffic(input int n);
        int          sent;
        int          pick;
        int          k;
        logic [15:0] a;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                if (!host_ctl[0]) begin
                    issue_access(ACT_HOST_REG, 16'($urandom), 1'b1, 8'($urandom) | 8'h01);
                    sent++;
                end
                issue_access(ACT_HOST_REG, 16'($urandom), 1'b1, bank_flip_data(6'($urandom)));
                sent++;
                if ($urandom_range(3) == 0) begin
                    issue_access(ACT_HOST_WINDOW, 16'($urandom_range(16'hBFFF, 16'h8000)),
                                 1'($urandom), 8'($urandom));
                    sent++;
                end
                k = $urandom_range(9);
                if (k < 8) a = window_addr(1'b1, 14'($urandom));
                else if (k == 8) a = {COPRO_REG_PAGE, 4'($urandom)};
                else a = 16'($urandom);
                issue_access(ACT_COPRO, a, 1'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 65) begin
                k = $urandom_range(3);
                case (k)
                    0: a = {COPRO_REG_PAGE, 4'($urandom)};
                    1: a = window_addr(1'b1, 14'($urandom));
                    2: a = window_addr(1'b0, 14'($urandom));
                    default: a = 16'($urandom);
                endcase
                issue_access(ACT_COPRO, a, 1'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 80) begin
                if ($urandom_range(4) != 0) a = 16'($urandom_range(16'hBFFF, 16'h8000));
                else a = 16'($urandom);
                issue_access(ACT_HOST_WINDOW, a, 1'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 90) begin
                issue_access(ACT_HOST_REG, 16'($urandom), 1'($urandom), 8'($urandom));
                sent++;
            end else begin
                issue_access(2'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    // control bytes and map straight out of reset
    task automatic test_reset_state();
        issue_access(ACT_HOST_REG, 16'h0000, 1'b0, 8'h00);
        issue_access(ACT_HOST_WINDOW, 16'h8000, 1'b0, 8'h00);
        issue_access(ACT_COPRO, 16'hFFFF, 1'b1, 8'hFF);
        issue_access(ACT_COPRO, 16'h4000, 1'b0, 8'h00);
        issue_access(ACT_COPRO, 16'h0000, 1'b0, 8'h00);
        issue_access(ACT_UNUSED, 16'hFFFF, 1'b1, 8'hFF);
    endtask

    // host control writes, forced bits, restart and both window halves
    task automatic test_host_control();
        issue_access(ACT_HOST_REG, 16'hFFFF, 1'b1, 8'h00);
        issue_access(ACT_HOST_REG, 16'h0000, 1'b1, 8'hFF);
        issue_access(ACT_HOST_WINDOW, 16'h8000, 1'b0, 8'h00);
        issue_access(ACT_HOST_WINDOW, 16'h9FFF, 1'b1, 8'hFF);
        issue_access(ACT_HOST_WINDOW, 16'hA000, 1'b0, 8'h00);
        issue_access(ACT_HOST_WINDOW, 16'hBFFF, 1'b0, 8'h00);
        issue_access(ACT_HOST_WINDOW, 16'h7FFF, 1'b0, 8'h00);
        issue_access(ACT_HOST_WINDOW, 16'hC000, 1'b0, 8'h00);
    endtask

    // semaphore bit crossing in both directions through the register mirror
    task automatic test_semaphore();
        issue_access(ACT_COPRO, 16'h020F, 1'b1, 8'hC0);
        issue_access(ACT_HOST_REG, 16'h0000, 1'b0, 8'h00);
        issue_access(ACT_HOST_REG, 16'h0000, 1'b1, 8'hFF);
        issue_access(ACT_COPRO, 16'h0200, 1'b0, 8'h00);
    endtask

    // bank swap hazard: hit, dormant access clear, clear on coprocessor reset
    task automatic test_bank_swap();
        issue_access(ACT_HOST_REG, 16'h0000, 1'b1, bank_flip_data(host_ctl[7:2]));
        issue_access(ACT_COPRO, window_addr(1'b1, 14'h0123), 1'b0, 8'h00);
        issue_access(ACT_HOST_REG, 16'h0000, 1'b1, bank_flip_data(host_ctl[7:2]));
        issue_access(ACT_COPRO, window_addr(1'b1, 14'h3FFF), 1'b1, 8'h5A);
        issue_access(ACT_HOST_REG, 16'h0000, 1'b1, bank_flip_data(host_ctl[7:2]));
        issue_access(ACT_COPRO, window_addr(1'b0, 14'h0000), 1'b0, 8'h00);
        issue_access(ACT_HOST_REG, 16'h0000, 1'b1, bank_flip_data(host_ctl[7:2]));
        issue_access(ACT_HOST_REG, 16'h0000, 1'b1, {host_ctl[7:1], 1'b0});
        issue_access(ACT_COPRO, window_addr(1'b1, 14'h2000), 1'b0, 8'h00);
    endtask

    // hazard disabled, seed at its top value
    task automatic test_hazard_off();
        wait_idle();
        write_setting(CFG_VERSION_ONE, '0);
        write_setting(CFG_RANDOM_SEED, SEED_MAX);
        run_traffic(400);
    endtask

    // hazard enabled with the seed at both ends of its range
    task automatic test_seed_extremes();
        wait_idle();
        write_setting(CFG_VERSION_ONE, SEED_W'(1));
        write_setting(CFG_RANDOM_SEED, SEED_MAX);
        run_traffic(200);
        wait_idle();
        write_setting(CFG_RANDOM_SEED, SEED_W'(1));
        run_traffic(200);
    endtask

    task automatic test_random_seeds();
        repeat (2) begin
            wait_idle();
            write_setting(CFG_RANDOM_SEED, SEED_W'($urandom_range(32'h7FFF_FFFF, 1)));
            run_traffic(200);
        end
    endtask

    // both sides at full rate for a long stretch
    task automatic test_full_rate();
        wait_idle();
        write_setting(CFG_RANDOM_SEED, SEED_W'($urandom_range(32'h7FFF_FFFF, 1)));
        no_idle = 1'b1;
        run_traffic(400);
        wait_idle();
        no_idle = 1'b0;
    endtask

    // result side: random stalls, compare each word with the oldest prediction
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 35);
        if (aresetn && m_valid && m_ready) begin
            if (access_results_due.size() == 0) begin
                log_fail("unexpected word", "none", show_word(m_data));
            end else begin
                want = access_results_due.pop_front();
                if (m_data.read_data !== want.read_data
                        || m_data.phys_address !== want.phys_address
                        || m_data.mapped !== want.mapped
                        || m_data.is_register !== want.is_register
                        || m_data.corrupt !== want.corrupt
                        || m_data.corrupt_mask !== want.corrupt_mask
                        || m_data.coproc_run !== want.coproc_run
                        || m_data.coproc_restart !== want.coproc_restart
                        || m_data.rd5_active !== want.rd5_active)
                    log_fail("word mismatch", show_word(want), show_word(m_data));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : run
        hazard_en   = 1'b1;
        host_ctl    = HOST_RESET_VAL;
        copro_ctl   = COPRO_RESET_VAL;
        swap_hazard = 1'b0;
        load_noise_seed(SEED_W'(1));
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_host_control();
        test_semaphore();
        test_bank_swap();
        test_hazard_off();
        test_seed_extremes();
        test_random_seeds();
        test_full_rate();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && access_results_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d words outstanding", fail_count,
                     access_results_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
